// ===== hdl/modular_inverse_euclid_defines.svh =====
// Assertion macros shared by the modular inverse block.
`ifndef MODULAR_INVERSE_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EUCLID_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define MIE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MIE_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define MIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/mie_pkg.sv =====
// Package of the modular inverse block: operation codes, status struct and microcode.
package mie_pkg;

   localparam int MOD_WIDTH_DEF = 32;
   localparam int EXP_WIDTH_DEF = 16;
   localparam int PC_W = 4;

   typedef enum logic [3:0] {
      OP_NOP       = 4'd0,
      OP_LOAD      = 4'd1,
      OP_DIV_START = 4'd2,
      OP_DIV_STEP  = 4'd3,
      OP_UPDATE    = 4'd4,
      OP_INIT_COEF = 4'd5,
      OP_REDUCE    = 4'd6,
      OP_EMIT_OK   = 4'd7,
      OP_EMIT_BAD  = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT       = 3'd0,
      COND_GOTO       = 3'd1,
      COND_WAIT_REQ   = 3'd2,
      COND_WAIT_OUT   = 3'd3,
      COND_RC_ZERO    = 3'd4,
      COND_RP_NOT_ONE = 3'd5,
      COND_LOOP       = 3'd6
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } ucode_type;

   typedef struct packed {
      logic rc_zero;
      logic rp_not_one;
      logic cnt_last;
   } stat_type;

   // Program addresses.
   localparam logic [PC_W-1:0] STEP_LOAD      = 4'd0;
   localparam logic [PC_W-1:0] STEP_MOD_ZERO  = 4'd1;
   localparam logic [PC_W-1:0] STEP_RED_DIV   = 4'd2;
   localparam logic [PC_W-1:0] STEP_RED_UPD   = 4'd3;
   localparam logic [PC_W-1:0] STEP_INIT_COEF = 4'd4;
   localparam logic [PC_W-1:0] STEP_TEST      = 4'd5;
   localparam logic [PC_W-1:0] STEP_DIV_START = 4'd6;
   localparam logic [PC_W-1:0] STEP_DIV       = 4'd7;
   localparam logic [PC_W-1:0] STEP_UPDATE    = 4'd8;
   localparam logic [PC_W-1:0] STEP_CHECK     = 4'd9;
   localparam logic [PC_W-1:0] STEP_REDUCE    = 4'd10;
   localparam logic [PC_W-1:0] STEP_EMIT_OK   = 4'd11;
   localparam logic [PC_W-1:0] STEP_EMIT_BAD  = 4'd12;

   // The microprogram: one control word per step.
   function automatic ucode_type ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         STEP_LOAD:      w = '{OP_LOAD,      COND_WAIT_REQ,   STEP_LOAD};
         STEP_MOD_ZERO:  w = '{OP_NOP,       COND_RC_ZERO,    STEP_EMIT_BAD};
         STEP_RED_DIV:   w = '{OP_DIV_STEP,  COND_LOOP,       STEP_RED_DIV};
         STEP_RED_UPD:   w = '{OP_UPDATE,    COND_NEXT,       STEP_LOAD};
         STEP_INIT_COEF: w = '{OP_INIT_COEF, COND_NEXT,       STEP_LOAD};
         STEP_TEST:      w = '{OP_NOP,       COND_RC_ZERO,    STEP_CHECK};
         STEP_DIV_START: w = '{OP_DIV_START, COND_NEXT,       STEP_LOAD};
         STEP_DIV:       w = '{OP_DIV_STEP,  COND_LOOP,       STEP_DIV};
         STEP_UPDATE:    w = '{OP_UPDATE,    COND_GOTO,       STEP_TEST};
         STEP_CHECK:     w = '{OP_NOP,       COND_RP_NOT_ONE, STEP_EMIT_BAD};
         STEP_REDUCE:    w = '{OP_REDUCE,    COND_NEXT,       STEP_LOAD};
         STEP_EMIT_OK:   w = '{OP_EMIT_OK,   COND_WAIT_OUT,   STEP_LOAD};
         STEP_EMIT_BAD:  w = '{OP_EMIT_BAD,  COND_WAIT_OUT,   STEP_LOAD};
         default:        w = '{OP_NOP,       COND_GOTO,       STEP_LOAD};
      endcase
      return w;
   endfunction

endpackage

// ===== hdl/modular_inverse_euclid.sv =====
// Each Euclid round runs a bit-serial division; a 16-bit exponent allows at most 23 rounds.
// One word is in work at a time; the sequencer is back at the load step, ready to take the next,
// in the cycle after the result is written, which may wait for the output register to free.
// Reset is synchronous and active high; it clears the step counter and the output valid.
`include "modular_inverse_euclid_defines.svh"
module modular_inverse_euclid #(
   parameter int MOD_WIDTH = mie_pkg::MOD_WIDTH_DEF,
   parameter int EXP_WIDTH = mie_pkg::EXP_WIDTH_DEF,
   localparam int REQ_W = ((EXP_WIDTH + MOD_WIDTH + 7) / 8) * 8,
   localparam int RSP_W = ((MOD_WIDTH + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,  // exponent, modulus
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,  // inverse
   output logic             rsp_tuser   // not_invertible
);

   mie_pkg::op_type      op;
   mie_pkg::stat_type    stat;
   logic [MOD_WIDTH-1:0] result;
   logic                 out_free;
   logic                 emit_op;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MOD_WIDTH-1:0] rsp_inverse_ff;
   logic                 rsp_bad_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit_op  = (op == mie_pkg::OP_EMIT_OK) || (op == mie_pkg::OP_EMIT_BAD);

   mie_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .out_free  (out_free),
      .stat      (stat),
      .req_ready (req_tready),
      .op        (op)
   );

   mie_datapath #(
      .MOD_WIDTH (MOD_WIDTH),
      .EXP_WIDTH (EXP_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .op       (op),
      .exponent (req_tdata[EXP_WIDTH-1:0]),
      .modulus  (req_tdata[EXP_WIDTH +: MOD_WIDTH]),
      .stat     (stat),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_op) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         mie_pkg::OP_EMIT_OK: begin
            rsp_inverse_ff <= result;
            rsp_bad_ff     <= 1'b0;
         end
         mie_pkg::OP_EMIT_BAD: begin
            rsp_inverse_ff <= '0;
            rsp_bad_ff     <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_inverse_ff);
   assign rsp_tuser  = rsp_bad_ff;

   // A result is never written over one that is still waiting to be taken.
   `MIE_ASSERT_IMPL(a_emit_into_free, clock, reset, emit_op, out_free, "result over full output")
   // A word just taken cannot produce its result in the following cycle.
   `MIE_ASSERT_NEXT(a_no_early_result, clock, reset, req_tvalid && req_tready, !emit_op,
                    "result issued straight after accept")
   // A flagged result always carries a zero inverse.
   `MIE_ASSERT_IMPL(a_bad_is_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_inverse_ff == '0,
                    "not invertible result with non-zero inverse")

endmodule

// ===== hdl/mie_seq.sv =====
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module mie_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              out_free,
   input  mie_pkg::stat_type stat,
   output logic              req_ready,
   output mie_pkg::op_type   op
);

   logic [mie_pkg::PC_W-1:0] pc_ff;
   logic [mie_pkg::PC_W-1:0] pc_in;
   mie_pkg::ucode_type       word;

   assign word      = mie_pkg::ucode(pc_ff);
   assign req_ready = (word.cond == mie_pkg::COND_WAIT_REQ) && !reset;

   always_comb begin
      op    = word.op;
      pc_in = pc_ff + mie_pkg::PC_W'(1);
      case (word.cond)
         mie_pkg::COND_NEXT: begin
         end
         mie_pkg::COND_GOTO: begin
            pc_in = word.target;
         end
         mie_pkg::COND_WAIT_REQ: begin
            if (!req_valid) begin
               op    = mie_pkg::OP_NOP;
               pc_in = pc_ff;
            end
         end
         mie_pkg::COND_WAIT_OUT: begin
            if (!out_free) begin
               op    = mie_pkg::OP_NOP;
               pc_in = pc_ff;
            end else begin
               pc_in = word.target;
            end
         end
         mie_pkg::COND_RC_ZERO: begin
            if (stat.rc_zero) pc_in = word.target;
         end
         mie_pkg::COND_RP_NOT_ONE: begin
            if (stat.rp_not_one) pc_in = word.target;
         end
         mie_pkg::COND_LOOP: begin
            if (!stat.cnt_last) pc_in = word.target;
         end
         default: begin
            op    = mie_pkg::OP_NOP;
            pc_in = mie_pkg::STEP_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= mie_pkg::STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hdl/mie_datapath.sv =====
// Datapath: remainders, signed-magnitude coefficients and a bit-serial divider.
module mie_datapath #(
   parameter int MOD_WIDTH = mie_pkg::MOD_WIDTH_DEF,
   parameter int EXP_WIDTH = mie_pkg::EXP_WIDTH_DEF
) (
   input  logic                 clock,
   input  mie_pkg::op_type      op,
   input  logic [EXP_WIDTH-1:0] exponent,
   input  logic [MOD_WIDTH-1:0] modulus,
   output mie_pkg::stat_type    stat,
   output logic [MOD_WIDTH-1:0] result
);

   localparam int DVD_W = (MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH;
   localparam int CNT_W = $clog2(DVD_W);

   logic [MOD_WIDTH-1:0] m_ff, rp_ff, rc_ff, cp_ff, cc_ff, rem_ff, acc_ff;
   logic                 np_ff, nc_ff;
   logic [DVD_W-1:0]     dvd_ff;
   logic [CNT_W-1:0]     cnt_ff;

   logic [MOD_WIDTH:0]   rem_sh;
   logic [MOD_WIDTH:0]   rem_sub;
   logic                 fits;
   logic [MOD_WIDTH-1:0] rem_in, acc_sh, acc_in, cp_red;

   // One restoring division step; the product quotient * cc builds up MSB first.
   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign rem_sub = rem_sh - {1'b0, rc_ff};
   assign fits    = (rem_sh >= {1'b0, rc_ff});
   assign rem_in  = fits ? rem_sub[MOD_WIDTH-1:0] : rem_sh[MOD_WIDTH-1:0];
   assign acc_sh  = {acc_ff[MOD_WIDTH-2:0], 1'b0};
   assign acc_in  = fits ? (acc_sh + cc_ff) : acc_sh;

   assign cp_red  = (cp_ff >= m_ff) ? (cp_ff - m_ff) : cp_ff;
   // A negative coefficient is brought into range by taking it from the modulus.
   assign result  = (np_ff && (cp_ff != '0)) ? (m_ff - cp_ff) : cp_ff;

   assign stat.rc_zero    = (rc_ff == '0);
   assign stat.rp_not_one = (rp_ff != MOD_WIDTH'(1));
   assign stat.cnt_last   = (cnt_ff == CNT_W'(DVD_W - 1));

   always_ff @(posedge clock) begin
      case (op)
         mie_pkg::OP_LOAD: begin
            // The first division reduces the exponent modulo the modulus.
            m_ff   <= modulus;
            rc_ff  <= modulus;
            dvd_ff <= DVD_W'(exponent);
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= '0;
         end
         mie_pkg::OP_DIV_START: begin
            dvd_ff <= DVD_W'(rp_ff);
            rem_ff <= '0;
            acc_ff <= '0;
            cnt_ff <= '0;
         end
         mie_pkg::OP_DIV_STEP: begin
            dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
            rem_ff <= rem_in;
            acc_ff <= acc_in;
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         mie_pkg::OP_UPDATE: begin
            rp_ff <= rc_ff;
            rc_ff <= rem_ff;
            cp_ff <= cc_ff;
            np_ff <= nc_ff;
            cc_ff <= cp_ff + acc_ff;
            nc_ff <= !nc_ff;
         end
         mie_pkg::OP_INIT_COEF: begin
            cp_ff <= '0;
            np_ff <= 1'b0;
            cc_ff <= MOD_WIDTH'(1);
            nc_ff <= 1'b0;
         end
         mie_pkg::OP_REDUCE: begin
            cp_ff <= cp_red;
         end
         default: begin
         end
      endcase
   end

endmodule
